[rtl/dfs_spf_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_spf_pkg
// shared types and codes of the depth-first path finder
// ----------------------------------------------------------------------------
package dfs_spf_pkg;

	localparam int OPCODE_W    = 2;
	localparam int VERTEX_W    = 4;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 5;
	localparam int VERTEX_SPAN = 1 << VERTEX_W;

	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FIND  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_PATH    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_PATH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

	localparam logic REG_VERTEX_COUNT = 1'b0;

	localparam logic [COUNT_W-1:0] VC_RESET = 5'd16;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [VERTEX_W-1:0] from_vertex;
		logic [VERTEX_W-1:0] to_vertex;
	} cmd_item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] path_vertex;
		logic                last;
		logic [STATUS_W-1:0] status;
	} res_item_t;

	typedef struct packed {
		logic                start;
		logic [VERTEX_W-1:0] from_vertex;
		logic [VERTEX_W-1:0] to_vertex;
		logic [COUNT_W-1:0]  vcount;
	} eng_req_t;

endpackage

[rtl/dfs_simple_path_finder_core.sv]
// ----------------------------------------------------------------------------
// dfs_simple_path_finder_core
// directed graph in a bit adjacency matrix with a depth-first path search
// ----------------------------------------------------------------------------
// cmd channel (valid/ready): one item clears the matrix, adds one edge or
// asks for a path from from_vertex to to_vertex
// res channel (valid/ready): a query returns the path, start to end, one
// item per vertex with last set on the end vertex, or one status item
// apb port: vertex_count at address 0
// clear and add edge give no item
// a query checks each pushed vertex against to_vertex, then tests the
// neighbours in its row in turn with the single neighbour test of the
// search sequencer; the path then leaves at one item per cycle while
// the receiver takes them
// cmd_ready is low while a query is in progress
// a stalled receiver holds the output register and path emission waits
// reset empties the matrix and sets vertex_count to 16
// ----------------------------------------------------------------------------
module dfs_simple_path_finder_core #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dfs_spf_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [dfs_spf_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [dfs_spf_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                  pready,
	input  logic                                  cmd_valid,
	output logic                                  cmd_ready,
	input  dfs_spf_pkg::cmd_item_t                cmd,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output dfs_spf_pkg::res_item_t                res
);

	localparam int NUM_V = (MAX_VERTICES < dfs_spf_pkg::VERTEX_SPAN) ?
		MAX_VERTICES : dfs_spf_pkg::VERTEX_SPAN;
	localparam int VW = $clog2(NUM_V);
	localparam int CNT_W = dfs_spf_pkg::COUNT_W;

	logic [CNT_W-1:0]       vc_q;
	logic [CNT_W-1:0]       n_eff;
	logic [NUM_V-1:0]       adj_q [NUM_V];
	logic                   res_valid_q;
	dfs_spf_pkg::res_item_t res_q;

	logic                   reg_idx;
	logic                   cmd_fire;
	logic                   edge_ok;
	logic                   eng_busy;
	logic [VW-1:0]          row_addr;
	logic [NUM_V-1:0]       row;
	logic                   eng_valid;
	logic                   eng_ready;
	dfs_spf_pkg::res_item_t eng_item;
	dfs_spf_pkg::eng_req_t  req;

	// apb register
	assign pready  = 1'b1;
	assign reg_idx = paddr[dfs_spf_pkg::APB_ADDR_W-1];

	always_comb begin
		prdata = '0;
		if (reg_idx == dfs_spf_pkg::REG_VERTEX_COUNT) begin
			prdata = dfs_spf_pkg::APB_DATA_W'(vc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= dfs_spf_pkg::VC_RESET;
		end else if (psel && penable && pwrite && pready
			&& reg_idx == dfs_spf_pkg::REG_VERTEX_COUNT) begin
			vc_q <= pwdata[CNT_W-1:0];
		end
	end

	assign n_eff = (vc_q > CNT_W'(NUM_V)) ? CNT_W'(NUM_V) : vc_q;

	// command intake and adjacency matrix
	assign cmd_ready = !eng_busy;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign edge_ok   = ({1'b0, cmd.from_vertex} < n_eff) && ({1'b0, cmd.to_vertex} < n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q <= '{default: '0};
		end else if (cmd_fire) begin
			case (cmd.opcode)
				dfs_spf_pkg::OP_CLEAR: begin
					adj_q <= '{default: '0};
				end
				dfs_spf_pkg::OP_ADD: begin
					if (edge_ok) begin
						adj_q[cmd.from_vertex[VW-1:0]][cmd.to_vertex[VW-1:0]] <= 1'b1;
					end
				end
				default: begin
					adj_q <= adj_q;
				end
			endcase
		end
	end

	assign row = adj_q[row_addr];

	always_comb begin
		req.start       = cmd_fire && (cmd.opcode == dfs_spf_pkg::OP_FIND);
		req.from_vertex = cmd.from_vertex;
		req.to_vertex   = cmd.to_vertex;
		req.vcount      = n_eff;
	end

	dfs_spf_engine #(
		.NUM_V(NUM_V)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.busy     (eng_busy),
		.row_addr (row_addr),
		.row      (row),
		.res_valid(eng_valid),
		.res_ready(eng_ready),
		.res_item (eng_item)
	);

	// output register
	assign eng_ready = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (eng_ready) begin
			res_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_ready && eng_valid) begin
			res_q <= eng_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/dfs_spf_engine.sv]
// ----------------------------------------------------------------------------
// dfs_spf_engine
// depth-first search sequencer: one neighbour test per cycle, path stack,
// backtracking and emission of the found path
// ----------------------------------------------------------------------------
module dfs_spf_engine #(
	parameter int NUM_V = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dfs_spf_pkg::eng_req_t  req,
	output logic                   busy,
	output logic [$clog2(NUM_V)-1:0] row_addr,
	input  logic [NUM_V-1:0]       row,
	output logic                   res_valid,
	input  logic                   res_ready,
	output dfs_spf_pkg::res_item_t res_item
);

	localparam int VW = $clog2(NUM_V);
	localparam int CW = VW + 1;
	localparam int DW = $clog2(NUM_V + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_STAT  = 3'd4;

	logic [2:0]    state_q;
	logic [VW-1:0] top_q;
	logic [VW-1:0] goal_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] scan_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] k_q;
	logic [dfs_spf_pkg::STATUS_W-1:0] stat_q;
	logic [NUM_V-1:0] visited_q;
	logic [VW-1:0] stack_q  [NUM_V];
	logic [CW-1:0] resume_q [NUM_V];

	logic [DW-1:0] depth_m1;
	logic [DW-1:0] depth_m2;
	logic [VW-1:0] rd_idx;
	logic [VW-1:0] stack_rd;
	logic [CW-1:0] resume_rd;
	logic [VW-1:0] scan_idx;
	logic [VW-1:0] from_idx;
	logic          scan_end;
	logic          scan_hit;
	logic          depth_full;
	logic          do_push;
	logic          do_pop;
	logic          emit_last;
	logic          range_bad;

	assign depth_m1   = depth_q - DW'(1);
	assign depth_m2   = depth_q - DW'(2);
	assign rd_idx     = (state_q == S_EMIT) ? k_q[VW-1:0] : depth_m2[VW-1:0];
	assign stack_rd   = stack_q[rd_idx];
	assign resume_rd  = resume_q[rd_idx];
	assign scan_idx   = scan_q[VW-1:0];
	assign from_idx   = req.from_vertex[VW-1:0];
	assign scan_end   = scan_q >= n_q;
	assign scan_hit   = row[scan_idx] && !visited_q[scan_idx];
	assign depth_full = depth_q == DW'(NUM_V);
	assign do_push    = (state_q == S_SCAN) && !scan_end && scan_hit && !depth_full;
	assign do_pop     = (state_q == S_SCAN) && (scan_end || (scan_hit && depth_full));
	assign emit_last  = (k_q + DW'(1)) == depth_q;
	assign range_bad  = ({1'b0, req.from_vertex} >= req.vcount)
		|| ({1'b0, req.to_vertex} >= req.vcount);

	assign busy     = state_q != S_IDLE;
	assign row_addr = top_q;

	always_comb begin
		res_valid = 1'b0;
		res_item  = '0;
		unique case (state_q)
			S_EMIT: begin
				res_valid            = 1'b1;
				res_item.path_vertex = dfs_spf_pkg::VERTEX_W'(stack_rd);
				res_item.last        = emit_last;
				res_item.status      = dfs_spf_pkg::ST_PATH;
			end
			S_STAT: begin
				res_valid       = 1'b1;
				res_item.last   = 1'b1;
				res_item.status = stat_q;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						if (range_bad) begin
							state_q <= S_STAT;
						end else begin
							state_q <= S_CHECK;
							depth_q <= DW'(1);
						end
					end
				end
				S_CHECK: begin
					state_q <= (top_q == goal_q) ? S_EMIT : S_SCAN;
				end
				S_SCAN: begin
					if (do_push) begin
						depth_q <= depth_q + DW'(1);
						state_q <= S_CHECK;
					end else if (do_pop) begin
						depth_q <= depth_m1;
						if (depth_q == DW'(1)) begin
							state_q <= S_STAT;
						end
					end
				end
				S_EMIT: begin
					if (res_ready && emit_last) begin
						state_q <= S_IDLE;
					end
				end
				S_STAT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers, written before each use
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				n_q    <= req.vcount[CW-1:0];
				top_q  <= from_idx;
				goal_q <= req.to_vertex[VW-1:0];
				scan_q <= '0;
				k_q    <= '0;
				stat_q <= dfs_spf_pkg::ST_RANGE;
				visited_q  <= {{(NUM_V-1){1'b0}}, 1'b1} << from_idx;
				stack_q[0] <= from_idx;
			end
			S_CHECK: begin
				k_q <= '0;
			end
			S_SCAN: begin
				if (do_push) begin
					resume_q[depth_m1[VW-1:0]] <= scan_q + CW'(1);
					visited_q[scan_idx]        <= 1'b1;
					stack_q[depth_q[VW-1:0]]   <= scan_idx;
					top_q                      <= scan_idx;
					scan_q                     <= '0;
				end else if (do_pop) begin
					top_q  <= stack_rd;
					scan_q <= resume_rd;
					stat_q <= dfs_spf_pkg::ST_NO_PATH;
				end else begin
					scan_q <= scan_q + CW'(1);
				end
			end
			S_EMIT: begin
				if (res_ready) begin
					k_q <= k_q + DW'(1);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule
